// ===== hw/rtl/jvtc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON value type classifier package
// Request types, classifier state, class and error codes, keyword tables.
// ----------------------------------------------------------------------------
package jvtc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } in_t;

  typedef struct packed {
    logic [2:0] value_class;
    logic [1:0] error_code;
  } out_t;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_STR      = 7'b0000010,
    PH_STR_TERM = 7'b0000100,
    PH_NUM_MANT = 7'b0001000,
    PH_NUM_DOT  = 7'b0010000,
    PH_NUM_EXP  = 7'b0100000,
    PH_KEYWORD  = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] keyword_pos;
    logic       last_was_backslash;
    logic       seen_dot;
    logic       is_float_flag;
    logic [1:0] keyword_kind;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase: PH_IDLE, keyword_pos: 3'd0, last_was_backslash: 1'b0,
    seen_dot: 1'b0, is_float_flag: 1'b0, keyword_kind: 2'd0
  };

  localparam logic [2:0] CLS_STRING = 3'd0;
  localparam logic [2:0] CLS_INT    = 3'd1;
  localparam logic [2:0] CLS_FLOAT  = 3'd2;
  localparam logic [2:0] CLS_NULL   = 3'd3;
  localparam logic [2:0] CLS_TRUE   = 3'd4;
  localparam logic [2:0] CLS_FALSE  = 3'd5;
  localparam logic [2:0] CLS_LIST   = 3'd6;
  localparam logic [2:0] CLS_OBJECT = 3'd7;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_INVALID = 2'd1;
  localparam logic [1:0] ERR_OPEN    = 2'd2;

  localparam logic [1:0] KW_NULL  = 2'd0;
  localparam logic [1:0] KW_TRUE  = 2'd1;
  localparam logic [1:0] KW_FALSE = 2'd2;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_ZERO      = 8'd48;
  localparam logic [7:0] CH_COLON     = 8'd58;
  localparam logic [7:0] CH_LOW_E     = 8'h65;
  localparam logic [7:0] CH_UP_E      = 8'h45;
  localparam logic [7:0] CH_LOW_N     = 8'h6E;
  localparam logic [7:0] CH_LOW_T     = 8'h74;
  localparam logic [7:0] CH_LOW_F     = 8'h66;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b < CH_COLON);
  endfunction

  function automatic logic is_terminator(input logic [7:0] b);
    return (b <= CH_SPACE) || (b == CH_RBRACKET) || (b == CH_RBRACE) ||
           (b == CH_COMMA);
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] kind);
    return (kind == KW_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [2:0] kw_class(input logic [1:0] kind);
    logic [2:0] c;
    case (kind)
      KW_NULL:  c = CLS_NULL;
      KW_TRUE:  c = CLS_TRUE;
      default:  c = CLS_FALSE;
    endcase
    return c;
  endfunction

  // "null", "true", "false"
  function automatic logic [7:0] kw_char(input logic [1:0] kind,
                                         input logic [2:0] pos);
    logic [7:0] c;
    c = CH_NUL;
    case (kind)
      KW_NULL: begin
        case (pos)
          3'd0:    c = 8'h6E;
          3'd1:    c = 8'h75;
          3'd2:    c = 8'h6C;
          3'd3:    c = 8'h6C;
          default: c = CH_NUL;
        endcase
      end
      KW_TRUE: begin
        case (pos)
          3'd0:    c = 8'h74;
          3'd1:    c = 8'h72;
          3'd2:    c = 8'h75;
          3'd3:    c = 8'h65;
          default: c = CH_NUL;
        endcase
      end
      KW_FALSE: begin
        case (pos)
          3'd0:    c = 8'h66;
          3'd1:    c = 8'h61;
          3'd2:    c = 8'h6C;
          3'd3:    c = 8'h73;
          3'd4:    c = 8'h65;
          default: c = CH_NUL;
        endcase
      end
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/jvtc_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JVTC byte step
// Combinational next-state and result logic for one byte of the stream.
// ----------------------------------------------------------------------------
module jvtc_step (
  input  jvtc_pkg::state_t cur,
  input  jvtc_pkg::in_t    item,
  output jvtc_pkg::state_t nxt,
  output logic             res_valid,
  output jvtc_pkg::out_t   res
);

  logic [7:0] b;
  logic       term;
  logic       dig;

  assign b    = item.data_byte;
  assign term = jvtc_pkg::is_terminator(b);
  assign dig  = jvtc_pkg::is_digit(b);

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    if (item.start_req) begin
      nxt = jvtc_pkg::STATE_RESET;
      if (b == jvtc_pkg::CH_QUOTE) begin
        nxt.phase = jvtc_pkg::PH_STR;
      end else if (b == jvtc_pkg::CH_MINUS || dig) begin
        nxt.phase = jvtc_pkg::PH_NUM_MANT;
      end else if (b == jvtc_pkg::CH_LOW_N || b == jvtc_pkg::CH_LOW_T ||
                   b == jvtc_pkg::CH_LOW_F) begin
        nxt.phase        = jvtc_pkg::PH_KEYWORD;
        nxt.keyword_pos  = 3'd1;
        nxt.keyword_kind = (b == jvtc_pkg::CH_LOW_N) ? jvtc_pkg::KW_NULL :
                           (b == jvtc_pkg::CH_LOW_T) ? jvtc_pkg::KW_TRUE :
                                                       jvtc_pkg::KW_FALSE;
      end else begin
        res_valid       = 1'b1;
        res.value_class = (b == jvtc_pkg::CH_LBRACKET) ? jvtc_pkg::CLS_LIST :
                          (b == jvtc_pkg::CH_LBRACE)   ? jvtc_pkg::CLS_OBJECT :
                                                         jvtc_pkg::CLS_STRING;
        res.error_code  = (b == jvtc_pkg::CH_LBRACKET || b == jvtc_pkg::CH_LBRACE)
                          ? jvtc_pkg::ERR_NONE : jvtc_pkg::ERR_INVALID;
      end
    end else begin
      case (cur.phase)
        jvtc_pkg::PH_IDLE: begin
          nxt = cur;
        end
        jvtc_pkg::PH_STR: begin
          if (b == jvtc_pkg::CH_NUL) begin
            res_valid      = 1'b1;
            res.error_code = jvtc_pkg::ERR_OPEN;
          end else if (b == jvtc_pkg::CH_QUOTE && !cur.last_was_backslash) begin
            nxt.phase = jvtc_pkg::PH_STR_TERM;
          end else begin
            nxt.last_was_backslash = (b == jvtc_pkg::CH_BACKSLASH);
          end
        end
        jvtc_pkg::PH_STR_TERM: begin
          res_valid       = 1'b1;
          res.value_class = jvtc_pkg::CLS_STRING;
          res.error_code  = term ? jvtc_pkg::ERR_NONE : jvtc_pkg::ERR_INVALID;
        end
        jvtc_pkg::PH_NUM_MANT: begin
          if (dig) begin
            nxt = cur;
          end else if (b == jvtc_pkg::CH_DOT) begin
            if (cur.seen_dot) begin
              res_valid      = 1'b1;
              res.error_code = jvtc_pkg::ERR_INVALID;
            end else begin
              nxt.seen_dot      = 1'b1;
              nxt.is_float_flag = 1'b1;
              nxt.phase         = jvtc_pkg::PH_NUM_DOT;
            end
          end else if (b == jvtc_pkg::CH_LOW_E || b == jvtc_pkg::CH_UP_E) begin
            nxt.is_float_flag = 1'b1;
            nxt.phase         = jvtc_pkg::PH_NUM_EXP;
          end else begin
            res_valid = 1'b1;
            if (term) begin
              res.value_class = cur.is_float_flag ? jvtc_pkg::CLS_FLOAT
                                                  : jvtc_pkg::CLS_INT;
            end else begin
              res.error_code = jvtc_pkg::ERR_INVALID;
            end
          end
        end
        jvtc_pkg::PH_NUM_DOT: begin
          if (dig) begin
            nxt.phase = jvtc_pkg::PH_NUM_MANT;
          end else begin
            res_valid      = 1'b1;
            res.error_code = jvtc_pkg::ERR_INVALID;
          end
        end
        jvtc_pkg::PH_NUM_EXP: begin
          if (!dig) begin
            res_valid = 1'b1;
            if (term) begin
              res.value_class = jvtc_pkg::CLS_FLOAT;
            end else begin
              res.error_code = jvtc_pkg::ERR_INVALID;
            end
          end
        end
        jvtc_pkg::PH_KEYWORD: begin
          if (cur.keyword_kind == 2'd3 ||
              cur.keyword_pos > jvtc_pkg::kw_len(cur.keyword_kind)) begin
            nxt = jvtc_pkg::STATE_RESET;
          end else if (cur.keyword_pos == jvtc_pkg::kw_len(cur.keyword_kind)) begin
            res_valid = 1'b1;
            if (term) begin
              res.value_class = jvtc_pkg::kw_class(cur.keyword_kind);
            end else begin
              res.error_code = jvtc_pkg::ERR_INVALID;
            end
          end else if (b != jvtc_pkg::kw_char(cur.keyword_kind, cur.keyword_pos)) begin
            res_valid      = 1'b1;
            res.error_code = jvtc_pkg::ERR_INVALID;
          end else begin
            nxt.keyword_pos = cur.keyword_pos + 3'd1;
          end
        end
        default: begin
          nxt = jvtc_pkg::STATE_RESET;
        end
      endcase
      if (res_valid) begin
        nxt = jvtc_pkg::STATE_RESET;
      end
    end
  end

endmodule

// ===== hw/rtl/json_value_type_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON value type classifier
// Streaming classifier of one JSON value per start byte: one byte a request.
// ----------------------------------------------------------------------------
// One byte is taken every cycle when the result side keeps up. A byte is held in
// the input register, is decoded by the step logic against the running
// classifier state, and any result lands in the output register. Brackets
// classify on their own byte; scalars on the terminator byte after them. A
// byte that carries start_req abandons any value in progress without a result.
// ----------------------------------------------------------------------------
module json_value_type_classifier (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  jvtc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output jvtc_pkg::out_t out_data
);

  logic              s1_valid_r;
  jvtc_pkg::in_t     s1_data_r;
  jvtc_pkg::state_t  state_r;
  jvtc_pkg::state_t  state_nxt;
  logic              out_valid_r;
  jvtc_pkg::out_t    out_data_r;
  logic              res_valid;
  jvtc_pkg::out_t    res;
  logic              adv;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  jvtc_step u_step (
    .cur       (state_r),
    .item      (s1_data_r),
    .nxt       (state_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= jvtc_pkg::STATE_RESET;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r && res_valid;
        if (s1_valid_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (adv && s1_valid_r && res_valid) begin
      out_data_r <= res;
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r.phase))
    else $error("classifier phase not one-hot");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_valid_r && res_valid) |=> (state_r == jvtc_pkg::STATE_RESET))
    else $error("state not cleared after result");

  a_error_class_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.error_code == jvtc_pkg::ERR_NONE ||
                     out_data_r.value_class == jvtc_pkg::CLS_STRING))
    else $error("error result with nonzero class");

  a_error_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.error_code != 2'd3))
    else $error("undefined error code");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output register");

endmodule
